// ----- rtl/core/rrm_pkg.sv -----
// rrm_pkg: widths, register indexes, controller states and the command and
// status words shared by the retrieval rank metrics core
// no dependencies
package rrm_pkg;

  localparam int MAX_ITEMS = 4096;
  localparam int POS_W     = $clog2(MAX_ITEMS + 1);
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 4;
  localparam int HITS_W    = 12;
  localparam int RSUM_W    = 27;
  localparam int FRAC_W    = 16;
  localparam int PSUM_W    = POS_W + FRAC_W;
  localparam int FIVEK_W   = CFG_W + 3;
  localparam int LIM_W     = CFG_W + 2;
  localparam int PROD_W    = CFG_W + FIVEK_W;
  localparam int NEG_W     = CFG_W + LIM_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int DIV_W     = PROD_W;
  localparam int STEP_W    = $clog2(FRAC_W);
  localparam int CMP_W     = (POS_W > CFG_W) ? POS_W : CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_GROUND_TRUTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF       = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] GROUND_TRUTH_RESET = CFG_W'(100);
  localparam logic [CFG_W-1:0] CUTOFF_RESET       = CFG_W'(200);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM_DIV,
    ST_TERM_ADD,
    ST_FIN_MUL,
    ST_FIN_LOAD_N,
    ST_FIN_DIV_N,
    ST_FIN_LOAD_A,
    ST_FIN_DIV_A,
    ST_FIN_OUT
  } rrm_state_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic add_term;
    logic fin_mul;
    logic load_nmrr;
    logic load_ap;
    logic emit;
  } rrm_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic need_div;
    logic last_in;
    logic last_q;
    logic div_last;
    logic out_free;
  } rrm_status_t;

endpackage

// ----- rtl/core/rrm_if.sv -----
// rrm_if: item, result and configuration channels of the rank metrics core
// depends on rrm_pkg
interface rrm_item_if;
  logic valid;
  logic ready;
  logic relevant;
  logic last;
  modport source (output valid, relevant, last, input ready);
  modport sink (input valid, relevant, last, output ready);
endinterface

interface rrm_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] nmrr_value;
  logic [15:0] avg_precision;
  logic        no_relevant;
  logic        bad_config;
  modport source (output valid, nmrr_value, avg_precision, no_relevant, bad_config,
                  input ready);
  modport sink (input valid, nmrr_value, avg_precision, no_relevant, bad_config,
                output ready);
endinterface

interface rrm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rrm_pkg::CFG_IDX_W-1:0] index;
  logic [rrm_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/rrm_divider.sv -----
// rrm_divider: shared radix-2 restoring divider, one quotient bit a cycle
// depends on rrm_pkg; remainder loaded below the divisor
module rrm_divider
  import rrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              step,
  input  logic [DIV_W-1:0]  load_rem,
  input  logic [DIV_W-1:0]  load_dvs,
  input  logic [FRAC_W-1:0] load_low,
  output logic [FRAC_W-1:0] quot,
  output logic              last_step
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [FRAC_W-1:0] low;
  logic [STEP_W-1:0] count;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial     = {rem, low[FRAC_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign last_step = count == STEP_W'(FRAC_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= '0;
    end else if (step) begin
      count <= count + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= load_rem;
      dvs  <= load_dvs;
      low  <= load_low;
      quot <= '0;
    end else if (step) begin
      if (fits) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
      low  <= {low[FRAC_W-2:0], 1'b0};
      quot <= {quot[FRAC_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/rrm_datapath.sv -----
// rrm_datapath: configuration registers, list counters, finishing arithmetic,
// the shared divider and the result register; depends on rrm_pkg, rrm_if, rrm_divider
module rrm_datapath
  import rrm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rrm_cmd_t            cmd,
  output rrm_status_t         status,
  rrm_item_if.sink            items,
  rrm_result_if.source        results,
  rrm_cfg_if.sink             cfg
);

  logic [CFG_W-1:0]   ng;
  logic [CFG_W-1:0]   k;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   relevant_seen;
  logic [HITS_W-1:0]  hits;
  logic [RSUM_W-1:0]  rank_sum_x4;
  logic [PSUM_W-1:0]  precision_sum;
  logic               last_q;

  logic [POS_W-1:0]   rank;
  logic [POS_W-1:0]   cnt;
  logic               in_range;
  logic               counts;
  logic               exact;
  logic               accept;

  logic [FIVEK_W-1:0] five_k;
  logic [LIM_W-1:0]   lim;
  logic [FIVEK_W-1:0] den_diff;
  logic [HITS_W-1:0]  h;
  logic               bad_c;

  logic [PROD_W-1:0]  p_den;
  logic [PROD_W-1:0]  p_pos;
  logic [NEG_W-1:0]   p_neg;
  logic               bad_q;
  logic               norel_q;
  logic               ap_sat_q;
  logic               zero_n;
  logic               sat_n;
  logic [FRAC_W-1:0]  nmrr_res;

  logic [NUM_W-1:0]   pos_part;
  logic [NUM_W-1:0]   num;

  logic               div_load;
  logic [DIV_W-1:0]   div_rem;
  logic [DIV_W-1:0]   div_dvs;
  logic [FRAC_W-1:0]  div_low;
  logic [FRAC_W-1:0]  quot;
  logic               div_last;

  logic               out_valid;
  logic               out_free;
  logic               emit_ok;
  logic [FRAC_W-1:0]  out_nmrr;
  logic [FRAC_W-1:0]  out_ap;
  logic               out_norel;
  logic               out_bad;

  assign cfg.ready   = 1'b1;
  assign items.ready = cmd.take;
  assign accept      = items.valid && cmd.take;

  assign in_range = position < POS_W'(MAX_ITEMS);
  assign rank     = position + POS_W'(1);
  assign cnt      = relevant_seen + POS_W'(1);
  assign counts   = in_range && items.relevant;
  assign exact    = cnt == rank;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ng <= GROUND_TRUTH_RESET;
      k  <= CUTOFF_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GROUND_TRUTH: ng <= cfg.data;
        REG_CUTOFF:       k  <= cfg.data;
        default: ;
      endcase
    end
  end

  // list counters
  always_ff @(posedge clk) begin
    if (rst || emit_ok) begin
      position      <= '0;
      relevant_seen <= '0;
      hits          <= '0;
      rank_sum_x4   <= '0;
      precision_sum <= '0;
      last_q        <= 1'b0;
    end else if (accept) begin
      last_q <= items.last;
      if (in_range) begin
        position <= rank;
      end
      if (counts) begin
        relevant_seen <= cnt;
        if (exact) begin
          precision_sum <= precision_sum +
                           {{(PSUM_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
        end
        if ((CMP_W'(rank) <= CMP_W'(k)) && (hits < ng)) begin
          hits        <= hits + HITS_W'(1);
          rank_sum_x4 <= rank_sum_x4 + RSUM_W'({rank, 2'b00});
        end
      end
    end else if (cmd.add_term) begin
      precision_sum <= precision_sum + PSUM_W'(quot);
    end
  end

  // finishing arithmetic
  assign five_k   = FIVEK_W'({k, 2'b00}) + FIVEK_W'(k);
  assign lim      = LIM_W'({ng, 1'b0}) + LIM_W'(2);
  assign den_diff = five_k - FIVEK_W'(lim);
  assign h        = (hits > ng) ? ng : hits;
  assign bad_c    = (ng == '0) || (k == '0) || (five_k <= FIVEK_W'(lim));

  assign pos_part = NUM_W'(rank_sum_x4) + NUM_W'(p_pos);
  assign num      = pos_part - NUM_W'(p_neg);

  always_ff @(posedge clk) begin
    if (cmd.fin_mul) begin
      p_den    <= PROD_W'(ng) * PROD_W'(den_diff);
      p_pos    <= PROD_W'(ng - h) * PROD_W'(five_k);
      p_neg    <= NEG_W'(ng) * NEG_W'(lim);
      bad_q    <= bad_c;
      norel_q  <= relevant_seen == '0;
      ap_sat_q <= precision_sum >= {relevant_seen, {FRAC_W{1'b0}}};
    end
    if (cmd.load_nmrr) begin
      zero_n <= pos_part <= NUM_W'(p_neg);
      sat_n  <= num >= NUM_W'(p_den);
    end
    if (cmd.load_ap) begin
      priority if (bad_q || zero_n) begin
        nmrr_res <= '0;
      end else if (sat_n) begin
        nmrr_res <= '1;
      end else begin
        nmrr_res <= quot;
      end
    end
  end

  // shared divider operands
  assign div_load = accept || cmd.load_nmrr || cmd.load_ap;

  always_comb begin
    priority if (cmd.load_nmrr) begin
      div_rem = num[DIV_W-1:0];
      div_dvs = p_den;
      div_low = '0;
    end else if (cmd.load_ap) begin
      div_rem = DIV_W'(precision_sum[PSUM_W-1:FRAC_W]);
      div_dvs = DIV_W'(relevant_seen);
      div_low = precision_sum[FRAC_W-1:0];
    end else begin
      div_rem = DIV_W'(cnt);
      div_dvs = DIV_W'(rank);
      div_low = '0;
    end
  end

  rrm_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .step      (cmd.div_step),
    .load_rem  (div_rem),
    .load_dvs  (div_dvs),
    .load_low  (div_low),
    .quot      (quot),
    .last_step (div_last)
  );

  // result register
  assign out_free = !out_valid || results.ready;
  assign emit_ok  = cmd.emit && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ok) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      out_nmrr  <= nmrr_res;
      out_norel <= norel_q;
      out_bad   <= bad_q;
      priority if (norel_q) begin
        out_ap <= '0;
      end else if (ap_sat_q) begin
        out_ap <= '1;
      end else begin
        out_ap <= quot;
      end
    end
  end

  assign results.valid         = out_valid;
  assign results.nmrr_value    = out_nmrr;
  assign results.avg_precision = out_ap;
  assign results.no_relevant   = out_norel;
  assign results.bad_config    = out_bad;

  assign status.in_valid = items.valid;
  assign status.need_div = counts && !exact;
  assign status.last_in  = items.last;
  assign status.last_q   = last_q;
  assign status.div_last = div_last;
  assign status.out_free = out_free;

`ifndef SYNTH
  a_hits_le_seen: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(hits) <= CMP_W'(relevant_seen))
    else $error("hit count above relevant count");

  a_seen_le_pos: assert property (@(posedge clk) disable iff (rst)
    relevant_seen <= position)
    else $error("relevant count above position");

  a_psum_bound: assert property (@(posedge clk) disable iff (rst)
    precision_sum <= {relevant_seen, {FRAC_W{1'b0}}})
    else $error("precision sum above relevant count");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit_ok |=> (position == '0) && (relevant_seen == '0) && out_valid)
    else $error("list not cleared after result");
`endif

endmodule

// ----- rtl/core/rrm_controller.sv -----
// rrm_controller: sequencer for item intake, precision term division and the
// end-of-list finishing pass; depends on rrm_pkg
module rrm_controller
  import rrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rrm_status_t status,
  output rrm_cmd_t    cmd
);

  rrm_state_t state;
  rrm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (status.in_valid) begin
          priority if (status.need_div) begin
            state_next = ST_TERM_DIV;
          end else if (status.last_in) begin
            state_next = ST_FIN_MUL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TERM_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_TERM_ADD;
        end
      end
      ST_TERM_ADD: begin
        cmd.add_term = 1'b1;
        state_next   = status.last_q ? ST_FIN_MUL : ST_IDLE;
      end
      ST_FIN_MUL: begin
        cmd.fin_mul = 1'b1;
        state_next  = ST_FIN_LOAD_N;
      end
      ST_FIN_LOAD_N: begin
        cmd.load_nmrr = 1'b1;
        state_next    = ST_FIN_DIV_N;
      end
      ST_FIN_DIV_N: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN_LOAD_A;
        end
      end
      ST_FIN_LOAD_A: begin
        cmd.load_ap = 1'b1;
        state_next  = ST_FIN_DIV_A;
      end
      ST_FIN_DIV_A: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN_OUT;
        end
      end
      ST_FIN_OUT: begin
        cmd.emit = 1'b1;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (state == ST_IDLE))
    else $error("item taken outside idle");

  a_div_runs_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TERM_DIV) && !status.div_last |=> (state == ST_TERM_DIV))
    else $error("term division left early");

  a_emit_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.out_free |=> (state == ST_IDLE))
    else $error("no return to idle after result");
`endif

endmodule

// ----- rtl/core/retrieval_rank_metrics_core.sv -----
// retrieval_rank_metrics_core: top level of the NMRR and average precision core
// depends on rrm_pkg, rrm_if, rrm_controller, rrm_datapath
//
// Takes a ranked list as one word per rank (relevant, last) and returns one result word
// per list with NMRR and average precision in Q0.16 plus the no_relevant and bad_config
// flags. A word that is not relevant, or is relevant with a precision term of exactly
// one, is taken with no division; a relevant word whose running count is below its rank
// goes through an intake, 16 steps of the shared radix-2 divider and one accumulate.
// The word marked last adds a finishing pass: a step of products, then two runs of the
// same divider, each a load and 16 steps, for NMRR and for average precision, then a
// transfer into the result register, which stalls the pass while an earlier result
// waits to be taken. No new word is taken until the block is back in idle.
// Configuration writes are taken at any time and are meant for an idle block.
module retrieval_rank_metrics_core
  import rrm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rrm_item_if.sink      items,
  rrm_result_if.source  results,
  rrm_cfg_if.sink       cfg
);

  rrm_cmd_t    cmd;
  rrm_status_t status;

  rrm_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rrm_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

endmodule
